FILE: sv/md5d_pkg.sv
// md5d_pkg: constants and round tables shared by the md5 digest block
`default_nettype none

package md5d_pkg;

   // chaining word initial values
   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   // first padding byte after the message
   localparam logic [7:0] PAD_BYTE = 8'h80;

   // byte count width (bit length wraps modulo 2^64)
   localparam int unsigned COUNT_W = 61;

   // additive round constant for round idx
   function automatic logic [31:0] round_key(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:  k = 32'hd76aa478;
         6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;
         6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;
         6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;
         6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;
         6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;
         6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;
         6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;
         6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;
         6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;
         6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;
         6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;
         6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;
         6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;
         6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;
         6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;
         6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;
         6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;
         6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;
         6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;
         6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;
         6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;
         6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;
         6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   // left rotate amount, selected by {round group, round low bits}
   function automatic logic [4:0] rot_amount(input logic [3:0] sel);
      logic [4:0] s;
      case (sel)
         4'd0:  s = 5'd7;
         4'd1:  s = 5'd12;
         4'd2:  s = 5'd17;
         4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;
         4'd5:  s = 5'd9;
         4'd6:  s = 5'd14;
         4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;
         4'd9:  s = 5'd11;
         4'd10: s = 5'd16;
         4'd11: s = 5'd23;
         4'd12: s = 5'd6;
         4'd13: s = 5'd10;
         4'd14: s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

FILE: sv/md5_digest.sv
// md5_digest: byte-serial md5 hash with one shared round unit
`default_nettype none

// channel   dir   handshake               payload
// req       in    req_tvalid/req_tready   tdata msg_byte, tuser byte_valid,
//                                         tlast end_of_message
// rsp       out   rsp_tvalid/rsp_tready   tdata word_a..word_d (128 bits)
//
// a word that does not complete a block is taken in S_IDLE, so bytes stream at one per
// cycle while req_tready is high; a word that completes a block runs 64 rounds through
// the single round unit, then folds into the chaining words in S_ADD
// an end-of-message word adds one or two padding blocks (S_PAD1, S_PAD2), each compressed
// like a full block, then S_OUT loads the result register; req_tready is low throughout
// synchronous reset restores the initial chaining words and a zero byte count
// the result register holds a digest while the next message streams in; S_OUT waits
// only when a second digest is ready before the first is taken

module md5_digest (
   input  wire logic         clock,
   input  wire logic         reset,
   // input words
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] msg_byte
   input  wire logic         req_tuser,   // [0] byte_valid
   input  wire logic         req_tlast,   // end_of_message
   // digest words
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata    // [31:0] word_a, [63:32] word_b,
                                          // [95:64] word_c, [127:96] word_d
);
   import md5d_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROUND = 3'd1;
   localparam logic [2:0] S_ADD   = 3'd2;
   localparam logic [2:0] S_PAD1  = 3'd3;
   localparam logic [2:0] S_PAD2  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   // what follows a compression
   localparam logic [1:0] POST_IDLE = 2'd0;
   localparam logic [1:0] POST_PAD1 = 2'd1;
   localparam logic [1:0] POST_PAD2 = 2'd2;
   localparam logic [1:0] POST_OUT  = 2'd3;

   logic [2:0]         state_ff, state_in;
   logic [1:0]         post_ff, post_in;
   logic [5:0]         round_ff, round_in;
   logic [31:0]        a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [31:0]        ch_a_ff, ch_a_in, ch_b_ff, ch_b_in;
   logic [31:0]        ch_c_ff, ch_c_in, ch_d_ff, ch_d_in;
   logic [31:0]        blk_ff [16];
   logic [31:0]        blk_in [16];
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [127:0]       rsp_data_ff, rsp_data_in;

   // round unit signals
   logic [31:0] fval;
   logic [3:0]  gidx;
   logic [3:0]  mi;
   logic [31:0] tsum;
   logic [4:0]  samt;
   logic [63:0] rot_wide;
   logic [31:0] b_next;
   logic [63:0] bit_len;
   logic [5:0]  pos;

   assign pos     = count_ff[5:0];
   assign bit_len = {count_ff, 3'b000};

   // one md5 round: boolean function, message index, add chain, rotate
   always_comb begin
      mi = round_ff[3:0];
      case (round_ff[5:4])
         2'd0: begin
            fval = (b_ff & c_ff) | (~b_ff & d_ff);
            gidx = mi;
         end
         2'd1: begin
            fval = (d_ff & b_ff) | (~d_ff & c_ff);
            gidx = 4'((mi << 2) + mi + 4'd1);
         end
         2'd2: begin
            fval = b_ff ^ c_ff ^ d_ff;
            gidx = 4'((mi << 1) + mi + 4'd5);
         end
         default: begin
            fval = c_ff ^ (b_ff | ~d_ff);
            gidx = 4'((mi << 3) - mi);
         end
      endcase
      tsum     = fval + a_ff + round_key(round_ff) + blk_ff[gidx];
      samt     = rot_amount({round_ff[5:4], round_ff[1:0]});
      rot_wide = {tsum, tsum} << samt;
      b_next   = b_ff + rot_wide[63:32];
   end

   // sequencer and datapath next values
   always_comb begin
      logic [5:0] idx;
      state_in     = state_ff;
      post_in      = post_ff;
      round_in     = round_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      ch_a_in      = ch_a_ff;
      ch_b_in      = ch_b_ff;
      ch_c_in      = ch_c_ff;
      ch_d_in      = ch_d_ff;
      blk_in       = blk_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      idx          = 6'd0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  // place the byte; the first lane of a word clears the rest
                  if (pos[1:0] == 2'd0) begin
                     blk_in[pos[5:2]] = {24'd0, req_tdata};
                  end else begin
                     blk_in[pos[5:2]][pos[1:0]*8 +: 8] = req_tdata;
                  end
                  count_in = count_ff + COUNT_W'(1);
               end
               if (req_tuser && pos == 6'd63) begin
                  post_in  = req_tlast ? POST_PAD1 : POST_IDLE;
                  a_in     = ch_a_ff;
                  b_in     = ch_b_ff;
                  c_in     = ch_c_ff;
                  d_in     = ch_d_ff;
                  round_in = 6'd0;
                  state_in = S_ROUND;
               end else if (req_tlast) begin
                  state_in = S_PAD1;
               end
            end
         end

         S_ROUND: begin
            a_in     = d_ff;
            d_in     = c_ff;
            c_in     = b_ff;
            b_in     = b_next;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = S_ADD;
            end
         end

         S_ADD: begin
            ch_a_in = ch_a_ff + a_ff;
            ch_b_in = ch_b_ff + b_ff;
            ch_c_in = ch_c_ff + c_ff;
            ch_d_in = ch_d_ff + d_ff;
            case (post_ff)
               POST_PAD1: state_in = S_PAD1;
               POST_PAD2: state_in = S_PAD2;
               POST_OUT:  state_in = S_OUT;
               default:   state_in = S_IDLE;
            endcase
         end

         S_PAD1: begin
            // keep message bytes, marker byte at pos, zeros after
            for (int w = 0; w < 16; w++) begin
               for (int l = 0; l < 4; l++) begin
                  idx = 6'(w * 4 + l);
                  if (idx == pos) begin
                     blk_in[w][l*8 +: 8] = PAD_BYTE;
                  end else if (idx > pos) begin
                     blk_in[w][l*8 +: 8] = 8'd0;
                  end
               end
            end
            if (pos < 6'd56) begin
               blk_in[14] = bit_len[31:0];
               blk_in[15] = bit_len[63:32];
               post_in    = POST_OUT;
            end else begin
               post_in    = POST_PAD2;
            end
            a_in     = ch_a_ff;
            b_in     = ch_b_ff;
            c_in     = ch_c_ff;
            d_in     = ch_d_ff;
            round_in = 6'd0;
            state_in = S_ROUND;
         end

         S_PAD2: begin
            // extra block of zeros and the bit length
            for (int w = 0; w < 14; w++) begin
               blk_in[w] = 32'd0;
            end
            blk_in[14] = bit_len[31:0];
            blk_in[15] = bit_len[63:32];
            post_in    = POST_OUT;
            a_in       = ch_a_ff;
            b_in       = ch_b_ff;
            c_in       = ch_c_ff;
            d_in       = ch_d_ff;
            round_in   = 6'd0;
            state_in   = S_ROUND;
         end

         S_OUT: begin
            // hand the digest to the result register and start a new message
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {ch_d_ff, ch_c_ff, ch_b_ff, ch_a_ff};
               ch_a_in      = INIT_A;
               ch_b_in      = INIT_B;
               ch_c_in      = INIT_C;
               ch_d_in      = INIT_D;
               count_in     = '0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and chaining registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         post_ff      <= POST_IDLE;
         round_ff     <= 6'd0;
         ch_a_ff      <= INIT_A;
         ch_b_ff      <= INIT_B;
         ch_c_ff      <= INIT_C;
         ch_d_ff      <= INIT_D;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         post_ff      <= post_in;
         round_ff     <= round_in;
         ch_a_ff      <= ch_a_in;
         ch_b_ff      <= ch_b_in;
         ch_c_ff      <= ch_c_in;
         ch_d_ff      <= ch_d_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working words, block buffer and result payload
   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      d_ff        <= d_in;
      blk_ff      <= blk_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
